>>> sv/dhm_pkg.sv
// shared types, constants and codes of the device health monitor
package dhm_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned CFG_W   = 3;

  localparam logic [7:0]  THRESH_RST   = 8'd3;
  localparam logic [15:0] CAP_RST      = 16'd5000;
  localparam logic [15:0] DEF_TMO_RST  = 16'd200;
  localparam logic [31:0] HOLD_RST     = 32'd30000;
  localparam logic [31:0] COOL_RST     = 32'd5000;
  localparam logic [4:0]  QDEV_RST     = 5'd3;
  localparam logic [4:0]  QDEG_RST     = 5'd2;
  localparam logic [6:0]  PCT_RST      = 7'd66;
  localparam logic [6:0]  HUNDRED      = 7'd100;

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_OUTCOME  = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_NOP      = 2'd3
  } dhm_mode_e;

  typedef enum logic [2:0] {
    CLS_NONE     = 3'd0,
    CLS_OVERFLOW = 3'd1,
    CLS_NACK     = 3'd2,
    CLS_TIMEOUT  = 3'd3,
    CLS_BUS      = 3'd4
  } dhm_cls_e;

  localparam logic [7:0] WS_OK       = 8'd0;
  localparam logic [7:0] WS_OVERFLOW = 8'd1;
  localparam logic [7:0] WS_NACK     = 8'd2;
  localparam logic [7:0] WS_TIMEOUT  = 8'd5;

  typedef enum logic [CFG_W-1:0] {
    CFG_THRESH   = 3'd0,
    CFG_CAP      = 3'd1,
    CFG_DEF_TMO  = 3'd2,
    CFG_HOLD     = 3'd3,
    CFG_COOL     = 3'd4,
    CFG_QDEV     = 3'd5,
    CFG_QDEG     = 3'd6,
    CFG_PCT      = 3'd7
  } dhm_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_QDEC,
    ST_RESULT
  } dhm_state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan_step;
    logic qdec;
    logic load_out;
  } dhm_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dhm_stat_t;

endpackage

>>> sv/dhm_if.sv
// channel interfaces: input item, result item and configuration write
interface dhm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  device_slot;
  logic [15:0] base_timeout_ms;
  logic [7:0]  wire_status;
  logic [31:0] now_ms;
  modport source (output valid, mode, device_slot, base_timeout_ms, wire_status, now_ms,
                  input ready);
  modport sink (input valid, mode, device_slot, base_timeout_ms, wire_status, now_ms,
                output ready);
endinterface

interface dhm_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  error_class;
  logic [7:0]  consecutive_errors;
  logic [15:0] total_errors;
  logic        degraded_now;
  logic [15:0] adaptive_timeout_ms;
  logic        recovery_request;
  logic        recovery_suppressed;
  modport source (output valid, error_class, consecutive_errors, total_errors, degraded_now,
                  adaptive_timeout_ms, recovery_request, recovery_suppressed,
                  input ready);
  modport sink (input valid, error_class, consecutive_errors, total_errors, degraded_now,
                adaptive_timeout_ms, recovery_request, recovery_suppressed,
                output ready);
endinterface

interface dhm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/device_health_monitor.sv
// device health monitor top level
//
// Tracks the health of up to sixteen device slots on one serial bus.
// item_i carries one request per transfer: register a slot, report a
// transaction outcome, clear a degraded mark, or do nothing. Each accepted
// item gives exactly one transfer on result_o with the addressed slot's
// state after the step and any bus recovery issued or withheld.
// cfg_i writes the eight configuration registers by index; it is always
// ready and should only be written while the block is idle.
// Each item passes the execute and result states. A NACK or timeout error
// on a registered slot that reaches the degrade threshold adds a scan over
// all slots through the single table read port and a quorum decision state.
// One item is in work at a time. item_i is ready again once the result
// sits in the output register, so the next item is taken while that
// result waits.
// A stalled receiver holds result_o; a second result then waits in the
// sequencer until the output register frees.
// Reset restores the configuration defaults, marks every slot unregistered
// and clears the recovery history.
module device_health_monitor import dhm_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  dhm_item_if.sink    item_i,
  dhm_result_if.source result_o,
  dhm_cfg_if.sink     cfg_i
);

  dhm_cmd_t  cmd;
  dhm_stat_t stat;

  assign cfg_i.ready = 1'b1;

  dhm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dhm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .mode_i     (item_i.mode),
    .slot_i     (item_i.device_slot),
    .btmo_i     (item_i.base_timeout_ms),
    .ws_i       (item_i.wire_status),
    .now_i      (item_i.now_ms),
    .cls_o      (result_o.error_class),
    .consec_o   (result_o.consecutive_errors),
    .total_o    (result_o.total_errors),
    .deg_now_o  (result_o.degraded_now),
    .adapt_o    (result_o.adaptive_timeout_ms),
    .req_o      (result_o.recovery_request),
    .sup_o      (result_o.recovery_suppressed)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("item accepted while previous one in work");

  a_req_sup_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.recovery_request && result_o.recovery_suppressed))
    else $error("recovery both issued and suppressed");

  a_sup_bus_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.recovery_suppressed |-> result_o.error_class == CLS_BUS)
    else $error("suppression without bus error");
`endif

endmodule

>>> sv/dhm_ctrl.sv
// sequencer of the device health monitor
module dhm_ctrl import dhm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dhm_stat_t stat_i,
  output dhm_cmd_t  cmd_o
);

  dhm_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:   state_d = stat_i.need_scan ? ST_SCAN : ST_RESULT;
      ST_SCAN:   if (stat_i.scan_last) state_d = ST_QDEC;
      ST_QDEC:   state_d = ST_RESULT;
      ST_RESULT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_EXEC:   cmd_o.exec = 1'b1;
      ST_SCAN:   cmd_o.scan_step = 1'b1;
      ST_QDEC:   cmd_o.qdec = 1'b1;
      ST_RESULT: cmd_o.load_out = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/dhm_datapath.sv
// slot table, configuration registers, update logic and result register
module dhm_datapath import dhm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dhm_cmd_t          cmd_i,
  output dhm_stat_t         stat_o,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [1:0]        mode_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [15:0]       btmo_i,
  input  logic [7:0]        ws_i,
  input  logic [31:0]       now_i,
  output logic [2:0]        cls_o,
  output logic [7:0]        consec_o,
  output logic [15:0]       total_o,
  output logic              deg_now_o,
  output logic [15:0]       adapt_o,
  output logic              req_o,
  output logic              sup_o
);

  // configuration
  logic [7:0]  thresh_q;
  logic [15:0] cap_q, def_tmo_q;
  logic [31:0] hold_q, cool_q;
  logic [4:0]  qdev_q, qdeg_q;
  logic [6:0]  pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      cap_q <= CAP_RST;
      def_tmo_q <= DEF_TMO_RST;
      hold_q <= HOLD_RST;
      cool_q <= COOL_RST;
      qdev_q <= QDEV_RST;
      qdeg_q <= QDEG_RST;
      pct_q <= PCT_RST;
    end else if (cfg_we_i) begin
      case (dhm_cfg_e'(cfg_idx_i))
        CFG_THRESH:  thresh_q <= cfg_data_i[7:0];
        CFG_CAP:     cap_q <= cfg_data_i[15:0];
        CFG_DEF_TMO: def_tmo_q <= cfg_data_i[15:0];
        CFG_HOLD:    hold_q <= cfg_data_i;
        CFG_COOL:    cool_q <= cfg_data_i;
        CFG_QDEV:    qdev_q <= cfg_data_i[4:0];
        CFG_QDEG:    qdeg_q <= cfg_data_i[4:0];
        CFG_PCT:     pct_q <= cfg_data_i[6:0];
        default:     thresh_q <= thresh_q;
      endcase
    end
  end

  // item
  dhm_mode_e         mode_q;
  logic [SLOT_W-1:0] slot_q;
  logic [15:0]       btmo_q;
  logic [7:0]        ws_q;
  logic [31:0]       now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= dhm_mode_e'(mode_i);
      slot_q <= slot_i;
      btmo_q <= btmo_i;
      ws_q <= ws_i;
      now_q <= now_i;
    end
  end

  // slot table
  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] deg_q;
  logic [15:0] base_q [SLOTS];
  logic [15:0] adapt_q [SLOTS];
  logic [7:0]  consec_q [SLOTS];
  logic [15:0] total_q [SLOTS];
  logic [31:0] lerr_q [SLOTS];
  logic [31:0] lrec_q;
  logic        once_q;

  logic [SLOT_W-1:0] scan_q;
  logic [CNT_W-1:0]  nreg_q, ndeg_q;
  logic [2:0]        cls_q;
  logic              req_q, sup_q;

  // one shared read port
  logic [SLOT_W-1:0] ra;
  logic              r_valid, r_deg, r_deg_now;
  logic [15:0]       r_base, r_adapt, r_total;
  logic [7:0]        r_consec;
  logic [31:0]       r_lerr, age;

  assign ra = cmd_i.scan_step ? scan_q : slot_q;
  assign r_valid = valid_q[ra];
  assign r_deg = deg_q[ra];
  assign r_base = base_q[ra];
  assign r_adapt = adapt_q[ra];
  assign r_consec = consec_q[ra];
  assign r_total = total_q[ra];
  assign r_lerr = lerr_q[ra];
  assign age = now_q - r_lerr;
  assign r_deg_now = r_deg && (age <= hold_q);

  // classification
  dhm_cls_e cls;
  always_comb begin
    cls = CLS_NONE;
    if (mode_q == MODE_OUTCOME) begin
      case (ws_q)
        WS_OK:       cls = CLS_NONE;
        WS_OVERFLOW: cls = CLS_OVERFLOW;
        WS_NACK:     cls = CLS_NACK;
        WS_TIMEOUT:  cls = CLS_TIMEOUT;
        default:     cls = CLS_BUS;
      endcase
    end
  end

  // update of the addressed slot
  logic        wr_en, w_valid, w_deg;
  logic [15:0] w_base, w_adapt, w_total, half, dbl_sat;
  logic [16:0] dbl;
  logic [7:0]  w_consec;
  logic [31:0] w_lerr, since_rec;
  logic        exec_rec, exec_sup, need_scan;

  assign half = {1'b0, r_adapt[15:1]};
  assign dbl = {r_adapt, 1'b0};
  assign dbl_sat = (dbl < {1'b0, cap_q}) ? dbl[15:0] : cap_q;
  assign since_rec = now_q - lrec_q;

  always_comb begin
    wr_en = 1'b0;
    w_valid = r_valid;
    w_base = r_base;
    w_adapt = r_adapt;
    w_consec = r_consec;
    w_total = r_total;
    w_deg = r_deg;
    w_lerr = r_lerr;
    exec_rec = 1'b0;
    exec_sup = 1'b0;
    need_scan = 1'b0;
    case (mode_q)
      MODE_REGISTER: begin
        wr_en = 1'b1;
        w_valid = 1'b1;
        w_base = (btmo_q != '0) ? btmo_q : ((def_tmo_q != '0) ? def_tmo_q : 16'd1);
        w_adapt = w_base;
        w_consec = '0;
        w_total = '0;
        w_deg = 1'b0;
        w_lerr = '0;
      end
      MODE_OUTCOME: begin
        wr_en = r_valid;
        if (cls == CLS_NONE) begin
          w_consec = '0;
          w_deg = 1'b0;
          if (r_adapt > r_base) w_adapt = (half > r_base) ? half : r_base;
        end else begin
          w_consec = (r_consec != '1) ? r_consec + 8'd1 : r_consec;
          w_total = (r_total != '1) ? r_total + 16'd1 : r_total;
          w_lerr = now_q;
          if (cls == CLS_TIMEOUT && r_adapt < cap_q) w_adapt = dbl_sat;
          if ((cls == CLS_NACK || cls == CLS_TIMEOUT) && w_consec >= thresh_q) begin
            w_deg = 1'b1;
            need_scan = r_valid;
          end
          if (cls == CLS_BUS && r_valid) begin
            if (once_q && since_rec < cool_q) exec_sup = 1'b1;
            else exec_rec = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        wr_en = r_valid && r_deg;
        w_deg = 1'b0;
        w_consec = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign stat_o.need_scan = need_scan;
  assign stat_o.scan_last = (scan_q == SLOT_W'(SLOTS - 1));

  // quorum decision
  logic [10:0] deg_pct;
  logic [11:0] reg_pct;
  logic        qdec_rec, recover;

  assign deg_pct = 11'(ndeg_q) * 11'(HUNDRED);
  assign reg_pct = 12'(pct_q) * 12'(nreg_q);
  assign qdec_rec = cmd_i.qdec && (nreg_q != '0) && (ndeg_q != '0)
                 && (nreg_q >= qdev_q) && (ndeg_q >= qdeg_q)
                 && ({1'b0, deg_pct} > reg_pct);
  assign recover = (cmd_i.exec && exec_rec) || qdec_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      lrec_q <= '0;
      once_q <= 1'b0;
    end else begin
      if (cmd_i.exec && wr_en) valid_q[slot_q] <= w_valid;
      if (recover) begin
        lrec_q <= now_q;
        once_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      base_q[slot_q] <= w_base;
      adapt_q[slot_q] <= w_adapt;
      consec_q[slot_q] <= w_consec;
      total_q[slot_q] <= w_total;
      deg_q[slot_q] <= w_deg;
      lerr_q[slot_q] <= w_lerr;
    end
    if (recover) begin
      deg_q <= '0;
      for (int i = 0; i < SLOTS; i++) consec_q[i] <= '0;
    end
  end

  // scan over the slots and per item flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      scan_q <= '0;
      nreg_q <= '0;
      ndeg_q <= '0;
      cls_q <= cls;
      req_q <= exec_rec;
      sup_q <= exec_sup;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + SLOT_W'(1);
      if (r_valid) begin
        nreg_q <= nreg_q + CNT_W'(1);
        if (r_deg_now) ndeg_q <= ndeg_q + CNT_W'(1);
      end
    end
    if (qdec_rec) req_q <= 1'b1;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cls_o <= cls_q;
      consec_o <= r_valid ? r_consec : '0;
      total_o <= r_valid ? r_total : '0;
      deg_now_o <= r_valid && r_deg_now;
      adapt_o <= r_valid ? r_adapt : '0;
      req_o <= req_q;
      sup_o <= sup_q;
    end
  end

endmodule
